// ===== design/mmlt_pkg.sv =====
// shared types, constants and helper functions of the mach limiter trigger
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mmlt_pkg;

    // width of the state fields at the ports, signed Q16.16 inside
    localparam int DATA_WIDTH = 32;

    // shared divider: left aligned numerator, up to 80 quotient bits
    localparam int NUM_W = 80;
    localparam int DEN_W = 50;
    localparam int CNT_W = 7;

    // square root unit: 48 bit radicand, 24 bit root
    localparam int SQ_W   = 48;
    localparam int ROOT_W = 24;

    localparam logic [CNT_W-1:0] NB_KH  = CNT_W'(64);
    localparam logic [CNT_W-1:0] NB_VEL = CNT_W'(48);
    localparam logic [CNT_W-1:0] NB_A2  = CNT_W'(49);
    localparam logic [CNT_W-1:0] NB_MSQ = CNT_W'(80);

    localparam logic [23:0] MACH_TEN = 24'd655360;
    localparam logic [23:0] MACH_SAT = 24'hFFFFFF;

    localparam logic [1:0] MODE_PRIM = 2'd0;
    localparam logic [1:0] MODE_CONS = 2'd1;

    localparam logic [1:0] CFG_VAR_MODE  = 2'd0;
    localparam logic [1:0] CFG_GAMMA     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [1:0]  RST_VAR_MODE  = 2'd0;
    localparam logic [13:0] RST_GAMMA     = 14'd6827;
    localparam logic [23:0] RST_THRESHOLD = 24'd78643;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] density;
        logic signed [DATA_WIDTH-1:0] comp_x;
        logic signed [DATA_WIDTH-1:0] comp_y;
        logic signed [DATA_WIDTH-1:0] comp_z;
        logic signed [DATA_WIDTH-1:0] mag_x;
        logic signed [DATA_WIDTH-1:0] mag_y;
        logic signed [DATA_WIDTH-1:0] mag_z;
        logic signed [DATA_WIDTH-1:0] press_or_energy;
        logic                         last_node;
    } t_in_item;

    typedef struct packed {
        logic        limit_on;
        logic [23:0] max_mach;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  var_mode;
        logic [13:0] gamma_ratio;
        logic [23:0] mach_threshold;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SQ_B,
        OP_SQ_C,
        OP_BH,
        OP_DIV_KH,
        OP_INNER,
        OP_PMUL,
        OP_PSET,
        OP_DIV_VEL,
        OP_VEL_SET,
        OP_PRIM_P,
        OP_GMUL,
        OP_DIV_A2,
        OP_A2_SET,
        OP_DIV_MSQ,
        OP_SQRT,
        OP_SET10,
        OP_SETSAT,
        OP_SET_ROOT,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic force10;
        logic cons;
        logic last;
        logic div_busy;
        logic sqrt_busy;
        logic gp_bad;
        logic a2_zero;
        logic msq_sat;
        logic out_full;
    } t_sts;

    // port field to Q16.16, saturated to the signed 32 bit range
    function automatic logic signed [31:0] field_q(input logic [DATA_WIDTH-1:0] x);
        logic signed [64:0] w;
        logic signed [31:0] r;
        w = 65'(signed'(x));
        if (w > 65'sd2147483647) r = 32'sh7FFFFFFF;
        else if (w < -65'sd2147483648) r = 32'sh80000000;
        else r = 32'(w);
        return r;
    endfunction

    // magnitude of a signed 32 bit value
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

// ===== design/mmlt_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on mmlt_pkg
`timescale 1ns / 1ps

module mmlt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mmlt_pkg::NUM_W-1:0]  i_num,
    input  logic [mmlt_pkg::DEN_W-1:0]  i_den,
    input  logic [mmlt_pkg::CNT_W-1:0]  i_nbits,
    output logic                        o_busy,
    output logic [mmlt_pkg::NUM_W-1:0]  o_quot
);
    import mmlt_pkg::*;

    logic [NUM_W-1:0] r_n;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0] rem_sh;
    logic           ge;
    logic [DEN_W:0] n_rem;

    always_comb begin
        rem_sh = {r_rem[DEN_W-1:0], r_n[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? rem_sh - {1'b0, r_den} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_nbits;
            r_n    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            // quotient bits enter at the bottom as numerator bits leave the top
            r_n   <= {r_n[NUM_W-2:0], ge};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_n;

endmodule

// ===== design/mmlt_sqrt.sv =====
// digit by digit integer square root, one root bit per cycle
// depends on mmlt_pkg
`timescale 1ns / 1ps

module mmlt_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mmlt_pkg::SQ_W-1:0]   i_x,
    output logic                        o_busy,
    output logic [mmlt_pkg::ROOT_W-1:0] o_root
);
    import mmlt_pkg::*;

    logic [SQ_W-1:0]   r_x;
    logic [ROOT_W+2:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem[ROOT_W:0], r_x[SQ_W-1:SQ_W-2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(ROOT_W);
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[SQ_W-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== design/mmlt_dpath.sv =====
// datapath: node registers, shared multiplier, divider and root units, running maximum
// depends on mmlt_pkg, mmlt_div and mmlt_sqrt
`timescale 1ns / 1ps

module mmlt_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmlt_pkg::t_cfg      i_cfg,
    input  logic                i_load,
    input  mmlt_pkg::t_in_item  i_item,
    input  mmlt_pkg::t_cmd      i_cmd,
    input  logic                i_out_ready,
    output mmlt_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output mmlt_pkg::t_out_item o_out_item
);
    import mmlt_pkg::*;

    logic signed [31:0] r_c [3];
    logic signed [31:0] r_b [3];
    logic signed [31:0] r_e;
    logic signed [32:0] r_d;
    logic               r_last;
    logic [63:0]        r_acc;
    logic [63:0]        r_prod;
    logic [46:0]        r_bh;
    logic signed [31:0] r_inner;
    logic               r_psign;
    logic signed [31:0] r_p;
    logic [49:0]        r_a2;
    logic [23:0]        r_mach;
    logic [23:0]        r_run;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [1:0]         k;
    logic [31:0]        dmag;
    logic signed [14:0] gm1;
    logic [14:0]        gm1_mag;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic               mul_en;
    logic [31:0]        sq_op;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [CNT_W-1:0]   div_nbits;
    logic               div_busy;
    logic [NUM_W-1:0]   div_q;
    logic               sqrt_start;
    logic               sqrt_busy;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [63:0]        khc;
    logic signed [64:0] kin;
    logic signed [64:0] inner_w;
    logic signed [64:0] p_w;
    logic [47:0]        vq;
    logic [30:0]        vqs;
    logic signed [31:0] vel;
    logic [23:0]        mx;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -65'sd2147483648) r = 32'sh80000000;
        else r = 32'(v);
        return r;
    endfunction

    always_comb begin
        k       = i_cmd.idx;
        dmag    = r_d[32] ? 32'(-r_d) : 32'(r_d);
        gm1     = signed'({1'b0, i_cfg.gamma_ratio}) - 15'sd4096;
        gm1_mag = gm1[14] ? 15'(-gm1) : 15'(gm1);

        // one shared 32x32 multiplier on magnitudes
        sq_op = '0;
        if (k != 2'd3) begin
            sq_op = (i_cmd.op == OP_SQ_B) ? mag32(r_b[k]) : mag32(r_c[k]);
        end
        mul_en = 1'b1;
        case (i_cmd.op)
            OP_SQ_B, OP_SQ_C: begin
                mul_a = sq_op;
                mul_b = sq_op;
            end
            OP_PMUL: begin
                mul_a = 32'(gm1_mag);
                mul_b = mag32(r_inner);
            end
            OP_GMUL: begin
                mul_a = 32'(i_cfg.gamma_ratio);
                mul_b = mag32(r_p);
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                mul_en = 1'b0;
            end
        endcase
        mul_p = mul_a * mul_b;

        // divider operands, numerator left aligned
        div_start = 1'b1;
        case (i_cmd.op)
            OP_DIV_KH: begin
                div_num   = {r_acc, 16'b0};
                div_den   = DEN_W'({dmag, 1'b0});
                div_nbits = NB_KH;
            end
            OP_DIV_VEL: begin
                div_num   = {(k != 2'd3) ? mag32(r_c[k]) : 32'd0, 48'b0};
                div_den   = DEN_W'(dmag);
                div_nbits = NB_VEL;
            end
            OP_DIV_A2: begin
                div_num   = {r_prod[44:0], 35'b0};
                div_den   = DEN_W'(dmag);
                div_nbits = NB_A2;
            end
            OP_DIV_MSQ: begin
                div_num   = {r_acc, 16'b0};
                div_den   = r_a2;
                div_nbits = NB_MSQ;
            end
            default: begin
                div_num   = '0;
                div_den   = '0;
                div_nbits = '0;
                div_start = 1'b0;
            end
        endcase
        sqrt_start = (i_cmd.op == OP_SQRT);

        // energy minus magnetic and kinetic parts
        khc     = (div_q[63:0] > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000
                                                          : div_q[63:0];
        kin     = r_d[32] ? -signed'({1'b0, khc}) : signed'({1'b0, khc});
        inner_w = 65'(r_e) - signed'({18'b0, r_bh}) - kin;

        // (gamma - 1) * inner / 4096, toward zero
        p_w = r_psign ? -signed'({32'b0, r_prod[44:12]}) : signed'({32'b0, r_prod[44:12]});

        // momentum over density, magnitude saturated
        vq  = div_q[47:0];
        vqs = (vq > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : vq[30:0];
        vel = ((k != 2'd3) && (r_c[k][31] != r_d[32])) ? -signed'({1'b0, vqs})
                                                       : signed'({1'b0, vqs});

        mx = (r_mach > r_run) ? r_mach : r_run;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_d    <= 33'(field_q(i_item.density)) + 33'sd1;
            r_c[0] <= field_q(i_item.comp_x);
            r_c[1] <= field_q(i_item.comp_y);
            r_c[2] <= field_q(i_item.comp_z);
            r_b[0] <= field_q(i_item.mag_x);
            r_b[1] <= field_q(i_item.mag_y);
            r_b[2] <= field_q(i_item.mag_z);
            r_e    <= field_q(i_item.press_or_energy);
            r_last <= i_item.last_node;
        end
        if (mul_en && !(((i_cmd.op == OP_SQ_B) || (i_cmd.op == OP_SQ_C)) && (k == 2'd3))) begin
            r_prod <= mul_p;
        end
        case (i_cmd.op)
            OP_SQ_B, OP_SQ_C: r_acc <= (k == 2'd0) ? 64'd0 : r_acc + r_prod;
            OP_BH:            r_bh <= r_acc[63:17];
            OP_INNER:         r_inner <= sat32(inner_w);
            OP_PMUL:          r_psign <= gm1[14] ^ r_inner[31];
            OP_PSET:          r_p <= sat32(p_w);
            OP_VEL_SET: begin
                if (k != 2'd3) begin
                    r_c[k] <= vel;
                end
            end
            OP_PRIM_P:        r_p <= r_e;
            OP_A2_SET:        r_a2 <= div_q[49:0];
            OP_SET10:         r_mach <= MACH_TEN;
            OP_SETSAT:        r_mach <= MACH_SAT;
            OP_SET_ROOT:      r_mach <= sqrt_root;
            default: begin
            end
        endcase
    end

    // running maximum and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_COMMIT) begin
                if (r_last) begin
                    r_out.limit_on <= mx > i_cfg.mach_threshold;
                    r_out.max_mach <= mx;
                    r_out_valid    <= 1'b1;
                    r_run          <= '0;
                end else begin
                    r_run <= mx;
                end
            end
        end
    end

    mmlt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_nbits (div_nbits),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    mmlt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (div_q[SQ_W-1:0]),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    always_comb begin
        o_sts.force10   = ((i_cfg.var_mode != MODE_PRIM) && (i_cfg.var_mode != MODE_CONS))
                          || (r_d == 33'sd0);
        o_sts.cons      = (i_cfg.var_mode == MODE_CONS);
        o_sts.last      = r_last;
        o_sts.div_busy  = div_busy;
        o_sts.sqrt_busy = sqrt_busy;
        o_sts.gp_bad    = (r_prod == 64'd0) || (r_p[31] != r_d[32]);
        o_sts.a2_zero   = (r_a2 == 50'd0);
        o_sts.msq_sat   = |div_q[NUM_W-1:SQ_W];
        o_sts.out_full  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== design/mmlt_ctrl.sv =====
// controller: sequences the datapath through one node per item
// depends on mmlt_pkg
`timescale 1ns / 1ps

module mmlt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_out_ready,
    input  mmlt_pkg::t_sts i_sts,
    output mmlt_pkg::t_cmd o_cmd,
    output logic           o_in_ready
);
    import mmlt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SQB, S_BH, S_SQM, S_KHGO, S_DWAIT, S_INNER, S_PMUL,
        S_PSET, S_VGO, S_VSET, S_PRIM, S_GMUL, S_GCHK, S_A2GO, S_A2SET, S_A2CHK,
        S_SQV, S_MSQGO, S_MSQCHK, S_SQGO, S_SWAIT, S_SET10, S_SETSAT, S_ROOT,
        S_WOUT, S_COMMIT
    } t_state;

    t_state r_state;
    t_state r_ret;
    t_op    r_ret_op;
    t_cmd   r_cmd;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_ret_op   <= OP_NONE;
            r_cmd      <= '{op: OP_NONE, idx: 2'd0};
            r_in_ready <= 1'b1;
        end else begin
            r_cmd.op <= OP_NONE;
            case (r_state)
                S_IDLE: begin
                    if (i_load) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_sts.force10) begin
                        r_state  <= S_SET10;
                        r_cmd.op <= OP_SET10;
                    end else if (i_sts.cons) begin
                        r_state <= S_SQB;
                        r_cmd   <= '{op: OP_SQ_B, idx: 2'd0};
                    end else begin
                        r_state  <= S_PRIM;
                        r_cmd.op <= OP_PRIM_P;
                    end
                end
                S_SQB: begin
                    if (r_cmd.idx == 2'd3) begin
                        r_state  <= S_BH;
                        r_cmd.op <= OP_BH;
                    end else begin
                        r_cmd <= '{op: OP_SQ_B, idx: r_cmd.idx + 2'd1};
                    end
                end
                S_BH: begin
                    r_state <= S_SQM;
                    r_cmd   <= '{op: OP_SQ_C, idx: 2'd0};
                end
                S_SQM: begin
                    if (r_cmd.idx == 2'd3) begin
                        r_state  <= S_KHGO;
                        r_cmd.op <= OP_DIV_KH;
                    end else begin
                        r_cmd <= '{op: OP_SQ_C, idx: r_cmd.idx + 2'd1};
                    end
                end
                S_KHGO: begin
                    r_state  <= S_DWAIT;
                    r_ret    <= S_INNER;
                    r_ret_op <= OP_INNER;
                end
                S_DWAIT: begin
                    if (!i_sts.div_busy) begin
                        r_state  <= r_ret;
                        r_cmd.op <= r_ret_op;
                    end
                end
                S_INNER: begin
                    r_state  <= S_PMUL;
                    r_cmd.op <= OP_PMUL;
                end
                S_PMUL: begin
                    r_state  <= S_PSET;
                    r_cmd.op <= OP_PSET;
                end
                S_PSET: begin
                    r_state <= S_VGO;
                    r_cmd   <= '{op: OP_DIV_VEL, idx: 2'd0};
                end
                S_VGO: begin
                    r_state  <= S_DWAIT;
                    r_ret    <= S_VSET;
                    r_ret_op <= OP_VEL_SET;
                end
                S_VSET: begin
                    if (r_cmd.idx == 2'd2) begin
                        r_state  <= S_GMUL;
                        r_cmd.op <= OP_GMUL;
                    end else begin
                        r_state <= S_VGO;
                        r_cmd   <= '{op: OP_DIV_VEL, idx: r_cmd.idx + 2'd1};
                    end
                end
                S_PRIM: begin
                    r_state  <= S_GMUL;
                    r_cmd.op <= OP_GMUL;
                end
                S_GMUL: begin
                    r_state <= S_GCHK;
                end
                S_GCHK: begin
                    if (i_sts.gp_bad) begin
                        r_state  <= S_SET10;
                        r_cmd.op <= OP_SET10;
                    end else begin
                        r_state  <= S_A2GO;
                        r_cmd.op <= OP_DIV_A2;
                    end
                end
                S_A2GO: begin
                    r_state  <= S_DWAIT;
                    r_ret    <= S_A2SET;
                    r_ret_op <= OP_A2_SET;
                end
                S_A2SET: begin
                    r_state <= S_A2CHK;
                end
                S_A2CHK: begin
                    if (i_sts.a2_zero) begin
                        r_state  <= S_SET10;
                        r_cmd.op <= OP_SET10;
                    end else begin
                        r_state <= S_SQV;
                        r_cmd   <= '{op: OP_SQ_C, idx: 2'd0};
                    end
                end
                S_SQV: begin
                    if (r_cmd.idx == 2'd3) begin
                        r_state  <= S_MSQGO;
                        r_cmd.op <= OP_DIV_MSQ;
                    end else begin
                        r_cmd <= '{op: OP_SQ_C, idx: r_cmd.idx + 2'd1};
                    end
                end
                S_MSQGO: begin
                    r_state  <= S_DWAIT;
                    r_ret    <= S_MSQCHK;
                    r_ret_op <= OP_NONE;
                end
                S_MSQCHK: begin
                    if (i_sts.msq_sat) begin
                        r_state  <= S_SETSAT;
                        r_cmd.op <= OP_SETSAT;
                    end else begin
                        r_state  <= S_SQGO;
                        r_cmd.op <= OP_SQRT;
                    end
                end
                S_SQGO: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (!i_sts.sqrt_busy) begin
                        r_state  <= S_ROOT;
                        r_cmd.op <= OP_SET_ROOT;
                    end
                end
                S_SET10, S_SETSAT, S_ROOT: begin
                    r_state <= S_WOUT;
                end
                S_WOUT: begin
                    // a cell result may only land in a free output register
                    if (!i_sts.last || !i_sts.out_full || i_out_ready) begin
                        r_state  <= S_COMMIT;
                        r_cmd.op <= OP_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_cmd      = r_cmd;
    assign o_in_ready = r_in_ready;

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd.op == OP_DIV_KH || r_cmd.op == OP_DIV_VEL || r_cmd.op == OP_DIV_A2 ||
         r_cmd.op == OP_DIV_MSQ) |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd.op == OP_SQRT) |-> !i_sts.sqrt_busy)
        else $error("root unit started while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd.op == OP_COMMIT && i_sts.last) |-> !i_sts.out_full)
        else $error("cell result overwrites a pending item");

endmodule

// ===== design/mhd_mach_limiter_trigger_unit.sv =====
// top level of the mhd mach limiter trigger: ports, configuration registers
// depends on mmlt_pkg, mmlt_ctrl and mmlt_dpath
`timescale 1ns / 1ps

// The block takes the corner nodes of one cell, one node per item, and computes
// each node's Mach number in fixed point (state fields signed Q16.16, Mach
// unsigned Q8.16, saturated at 0xFFFFFF). A running maximum is kept over the
// nodes; the item flagged last_node produces one result item with the maximum
// and limit_on, set when that maximum is strictly above mach_threshold, and the
// maximum is cleared for the next cell. Other nodes produce no result.
// var_mode selects primitive (0) or conservative (1) inputs; any other code
// gives every node Mach 10, as do a zero density-plus-epsilon and a sound
// speed below one lsb. One item is processed at a time. The time a node takes
// is set by the shared restoring divider, which produces one quotient bit per
// cycle (velocity divides 48 bits, kinetic energy 64, sound speed 49, Mach
// squared 80), and by the bit-serial square root of 24 root bits. A finished
// result waits in an output register, so the next node is accepted while it is
// pending; only a following cell result stalls until it is taken.
// Configuration writes are always accepted and are meant to happen only while
// the block is idle.
module mhd_mach_limiter_trigger_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // node items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mmlt_pkg::t_in_item  i_in_item,
    // cell result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mmlt_pkg::t_out_item o_out_item,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import mmlt_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic load;

    // an item is taken only while the sequencer sits idle
    assign load        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // configuration registers, index 3 is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.var_mode       <= RST_VAR_MODE;
            r_cfg.gamma_ratio    <= RST_GAMMA;
            r_cfg.mach_threshold <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VAR_MODE:  r_cfg.var_mode       <= i_cfg_data[1:0];
                CFG_GAMMA:     r_cfg.gamma_ratio    <= i_cfg_data[13:0];
                CFG_THRESHOLD: r_cfg.mach_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer: one command per cycle into the datapath
    mmlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready)
    );

    // arithmetic, running maximum and the output register
    mmlt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_load      (load),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/tb_mhd_mach_limiter_trigger_unit.sv =====
// self-checking bench for the mhd mach limiter trigger unit
// depends on mmlt_pkg and mhd_mach_limiter_trigger_unit; a scoreboard class
// predicts each cell's max mach and limit flag, tasks drive the ports
`timescale 1ns / 1ps

class mach_scoreboard;
    logic [1:0]  mode;
    logic [13:0] gamma;
    logic [23:0] thresh;
    logic [23:0] run_max;
    mmlt_pkg::t_out_item cell_q[$];
    int errors;

    function new();
        mode = mmlt_pkg::RST_VAR_MODE;
        gamma = mmlt_pkg::RST_GAMMA;
        thresh = mmlt_pkg::RST_THRESHOLD;
        run_max = 0;
        errors = 0;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // floor(num * 2^sh / den) clamped at lim
    function longint unsigned scaled_div(longint unsigned num, longint unsigned den,
                                         int sh, longint unsigned lim);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q >= lim) return lim;
        for (int i = 0; i < sh; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
            if (q >= lim) return lim;
        end
        return q;
    endfunction

    function logic [23:0] int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 46;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res[23:0];
    endfunction

    function longint vel(longint m, longint d);
        longint unsigned q;
        q = (absv(m) << 16) / absv(d);
        if (q > 64'd2147483647) q = 64'd2147483647;
        return ((m < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function logic [23:0] node_mach(mmlt_pkg::t_in_item it);
        longint d, c0, c1, c2, p, gp, kin, inr, bx, by, bz;
        longint unsigned m2, b2, kh, a2, v2, msq;
        d = longint'(it.density) + 1;
        c0 = it.comp_x;
        c1 = it.comp_y;
        c2 = it.comp_z;
        if (mode > mmlt_pkg::MODE_CONS || d == 0) return mmlt_pkg::MACH_TEN;
        if (mode == mmlt_pkg::MODE_PRIM) begin
            p = it.press_or_energy;
        end else begin
            bx = it.mag_x;
            by = it.mag_y;
            bz = it.mag_z;
            m2 = absv(c0) * absv(c0) + absv(c1) * absv(c1) + absv(c2) * absv(c2);
            b2 = absv(bx) * absv(bx) + absv(by) * absv(by) + absv(bz) * absv(bz);
            kh = m2 / (2 * absv(d));
            if (kh > (64'd1 << 62)) kh = 64'd1 << 62;
            kin = d < 0 ? -longint'(kh) : longint'(kh);
            inr = sat32(longint'(it.press_or_energy) - longint'(b2 >> 17) - kin);
            p = sat32((longint'(gamma) - 4096) * inr / 4096);
            c0 = vel(c0, d);
            c1 = vel(c1, d);
            c2 = vel(c2, d);
        end
        gp = longint'(gamma) * p;
        if (gp == 0 || ((gp < 0) != (d < 0))) return mmlt_pkg::MACH_TEN;
        a2 = (absv(gp) << 4) / absv(d);
        if (a2 == 0) return mmlt_pkg::MACH_TEN;
        v2 = absv(c0) * absv(c0) + absv(c1) * absv(c1) + absv(c2) * absv(c2);
        msq = scaled_div(v2, a2, 16, 64'd1 << 48);
        if (msq >= (64'd1 << 48)) return mmlt_pkg::MACH_SAT;
        return int_sqrt(msq);
    endfunction

    function void note_node(mmlt_pkg::t_in_item it);
        logic [23:0] m;
        mmlt_pkg::t_out_item r;
        m = node_mach(it);
        if (m > run_max) run_max = m;
        if (it.last_node) begin
            r.limit_on = run_max > thresh;
            r.max_mach = run_max;
            cell_q.push_back(r);
            run_max = 0;
        end
    endfunction

    function void check_cell(mmlt_pkg::t_out_item got);
        mmlt_pkg::t_out_item e;
        if (cell_q.size() == 0) begin
            $error("unexpected cell result %h", got);
            errors++;
            return;
        end
        e = cell_q.pop_front();
        if (got.limit_on !== e.limit_on) begin
            $error("limit_on: expected %0d, got %0d", e.limit_on, got.limit_on);
            errors++;
        end
        if (got.max_mach !== e.max_mach) begin
            $error("max_mach: expected %h, got %h", e.max_mach, got.max_mach);
            errors++;
        end
    endfunction
endclass

module tb_mhd_mach_limiter_trigger_unit;
    import mmlt_pkg::*;

    localparam int WATCHDOG = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    mach_scoreboard sb;
    int  send_idle_pct;   // percent of cycles the node sender idles
    int  recv_stall_pct;  // percent of cycles the result side stalls
    int  hold_cycles;     // long result hold-off request, counted by the sink
    int  idle_count;

    mhd_mach_limiter_trigger_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result sink: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_cell(o_out_item);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG) begin
            $display("mhd_mach_limiter_trigger_unit regression: fail");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_VAR_MODE:  sb.mode = val[1:0];
            CFG_GAMMA:     sb.gamma = val[13:0];
            CFG_THRESHOLD: sb.thresh = val;
            default: ;
        endcase
    endtask

    // one node item; valid stays high across back-to-back items
    task automatic send_node(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_node(it);
    endtask

    task automatic stop_sending();
        i_in_valid <= 0;
        @(posedge i_clk);
    endtask

    // wait until every cell result is in, then let the last node drain
    task automatic drain();
        stop_sending();
        while (sb.cell_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(32'h0004_0000) ;
            2: return -$urandom_range(32'h0004_0000);
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return $urandom_range(32'h0000_0FFF);
        endcase
    endfunction

    // mostly plausible physics states, some full-range noise
    function automatic t_in_item rnd_node(bit last);
        t_in_item it;
        bit wild;
        wild = ($urandom_range(9) == 0);
        it.density = wild ? rnd_val($urandom_range(5)) : 32'h1000 + $urandom_range(32'h4_0000);
        it.comp_x = rnd_val(wild ? $urandom_range(5) : $urandom_range(1, 2));
        it.comp_y = rnd_val(wild ? $urandom_range(5) : $urandom_range(1, 2));
        it.comp_z = rnd_val(wild ? $urandom_range(5) : $urandom_range(1, 2));
        it.mag_x = rnd_val(wild ? $urandom_range(5) : 5);
        it.mag_y = rnd_val(wild ? $urandom_range(5) : 5);
        it.mag_z = rnd_val(wild ? $urandom_range(5) : 5);
        it.press_or_energy = wild ? rnd_val($urandom_range(5))
                                  : $urandom_range(32'h100, 32'h40_0000);
        if ($urandom_range(19) == 0) it.density = 32'hFFFF_FFFF; // d of zero
        it.last_node = last;
        return it;
    endfunction

    task automatic run_cells(int n_nodes);
        int left;
        left = n_nodes;
        while (left > 0) begin
            // corner count of 1..8 nodes per cell
            int k;
            k = $urandom_range(1, 8);
            for (int j = 0; j < k && left > 0; j++) begin
                send_node(rnd_node(j == k - 1 || left == 1));
                left--;
            end
        end
    endtask

    initial begin
        t_in_item it;
        logic [23:0] gam_set[4];
        sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_VAR_MODE;
        i_cfg_data = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        idle_count = 0;
        gam_set = '{24'd4096, 24'd6827, 24'd16383, 24'd5461};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, zero denominator, every mode
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_VAR_MODE, 24'(m));
            it = '0;
            it.density = 32'h0001_0000;
            it.comp_x = 32'h0002_0000;
            it.press_or_energy = 32'h0001_0000;
            send_node(it);
            it = '1;
            it.last_node = 0;
            send_node(it);                         // density -lsb: d zero
            it = '0;
            it.density = 32'h7FFF_FFFF;
            it.comp_x = 32'h8000_0000;
            it.comp_y = 32'h7FFF_FFFF;
            it.comp_z = 32'h8000_0000;
            it.mag_x = 32'h7FFF_FFFF;
            it.mag_y = 32'h8000_0000;
            it.mag_z = 32'h7FFF_FFFF;
            it.press_or_energy = 32'h7FFF_FFFF;
            send_node(it);
            it = '0;
            it.density = 32'h0000_0001;
            it.comp_x = 32'h7FFF_FFFF;              // huge mach, saturates
            it.press_or_energy = 32'h0000_0001;
            it.last_node = 1;
            send_node(it);
            drain();
        end
        write_reg(CFG_VAR_MODE, 24'(MODE_PRIM));
        write_reg(CFG_THRESHOLD, 24'd0);
        it = '0;
        it.density = 32'h8000_0000;                // negative density
        it.press_or_energy = 32'h0001_0000;
        it.last_node = 1;
        send_node(it);
        drain();

        // random phases over settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_VAR_MODE, 24'((ph % 4 == 3) ? $urandom_range(2, 3) : ph % 2));
            write_reg(CFG_GAMMA, gam_set[ph % 4]);
            write_reg(CFG_THRESHOLD, (ph == 2) ? 24'hFFFFFF :
                                     (ph == 5) ? 24'd0 : 24'($urandom_range(24'h3_0000)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (ph == 4) hold_cycles = 6000;        // result side holds off
            run_cells(70);
            drain();
        end

        if (sb.errors == 0 && sb.cell_q.size() == 0) begin
            $display("mhd_mach_limiter_trigger_unit regression: pass");
        end else begin
            $display("mhd_mach_limiter_trigger_unit regression: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/mmlt_pkg.sv
design/mmlt_div.sv
design/mmlt_sqrt.sv
design/mmlt_dpath.sv
design/mmlt_ctrl.sv
design/mhd_mach_limiter_trigger_unit.sv
tb/tb_mhd_mach_limiter_trigger_unit.sv
